FILE: hdl/lfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

    // Table geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int RANK_W   = $clog2(CAPACITY);
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int CFG_W = 5;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Command codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [RANK_W-1:0] t_rank;
    typedef logic [CNT_W-1:0]  t_cnt;

endpackage

`default_nettype wire

FILE: hdl/lfu_cache_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// LFU key-value table with LRU tie-break, CAPACITY entries held in flip-flops.
//
// Request channel: drive i_command, i_key and i_value and raise start; the
// request is taken at the rising edge where start is high and busy is low.
// busy then stays high until the result is shown.
// Result channel: o_valid is high for exactly one cycle with o_hit,
// o_read_value, o_evicted and o_evicted_key; the receiver cannot stall, so
// the result must be taken in that cycle.
// Sequence: after acceptance the shared key/victim compare unit walks the
// table one entry per cycle, then the table is written back, then the
// result is shown. A new request can be taken in the cycle the result is
// shown, but not while an earlier request is still in progress.
// Configuration: i_cfg_data (capacity) is written when i_cfg_valid and
// o_cfg_ready are both high; o_cfg_ready is always high. Write it only
// while the block is idle.
// Reset (synchronous, active low): all entries invalid, occupancy zero,
// capacity 16, block idle. No clearing pass is needed.

module lfu_cache_table_unit
    import lfu_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // request channel
    input  wire                     start,
    output logic                    busy,
    input  wire                     i_command,
    input  wire signed [KEY_W-1:0]  i_key,
    input  wire signed [VAL_W-1:0]  i_value,
    // result channel
    output logic                    o_valid,
    output logic                    o_hit,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic                    o_evicted,
    output logic signed [KEY_W-1:0] o_evicted_key,
    // configuration channel
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire [CFG_W-1:0]         i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;

    localparam logic [CFG_W-1:0] CAP_LIM  = CFG_W'(CAPACITY);
    localparam t_idx             LAST_IDX = IDX_W'(CAPACITY - 1);

    // Entry table
    logic [CAPACITY-1:0] r_valid;
    logic [KEY_W-1:0]    r_key   [CAPACITY];
    logic [VAL_W-1:0]    r_value [CAPACITY];
    t_cnt                r_count [CAPACITY];
    t_rank               r_rank  [CAPACITY];
    logic [OCC_W-1:0]    r_occ;
    logic [CFG_W-1:0]    r_capacity;

    // Sequencer and latched request
    logic [1:0]       r_state;
    t_idx             r_ptr;
    logic             r_cmd;
    logic [KEY_W-1:0] r_key_in;
    logic [VAL_W-1:0] r_val_in;

    // Scan results
    logic             r_hit_f;
    t_idx             r_hit_idx;
    logic [VAL_W-1:0] r_hit_val;
    t_rank            r_hit_rank;
    t_cnt             r_hit_cnt;
    logic             r_free_f;
    t_idx             r_free_idx;
    logic             r_vic_f;
    t_idx             r_vic_idx;
    t_cnt             r_vic_cnt;
    t_rank            r_vic_rank;
    logic [KEY_W-1:0] r_vic_key;

    // Output registers
    logic             r_o_valid;
    logic             r_o_hit;
    logic [VAL_W-1:0] r_o_rv;
    logic             r_o_ev;
    logic [KEY_W-1:0] r_o_evk;

    logic                accept;
    logic [CFG_W-1:0]    cap_eff;
    logic                cur_valid;
    logic                key_match;
    logic                vic_better;
    logic                do_bump;
    logic                do_ins;
    logic                do_evict;
    logic                val_we;
    t_idx                wr_idx;
    t_cnt                wr_cnt;
    logic [CAPACITY-1:0] n_valid;
    t_rank               n_rank [CAPACITY];
    logic [OCC_W-1:0]    n_occ;

    assign accept      = start && (r_state == ST_IDLE);
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Clamp capacity to the table size
    assign cap_eff = (r_capacity > CAP_LIM) ? CAP_LIM : r_capacity;

    // Shared compare unit: one entry per cycle at r_ptr
    assign cur_valid  = r_valid[r_ptr];
    assign key_match  = cur_valid && (r_key[r_ptr] == r_key_in);
    assign vic_better = cur_valid && (!r_vic_f || (r_count[r_ptr] < r_vic_cnt) ||
                        ((r_count[r_ptr] == r_vic_cnt) && (r_rank[r_ptr] > r_vic_rank)));

    // Write-back decision and parallel rank update
    always_comb begin
        do_bump  = 1'b0;
        do_ins   = 1'b0;
        do_evict = 1'b0;
        val_we   = 1'b0;
        wr_idx   = r_hit_idx;
        n_valid  = r_valid;
        n_occ    = r_occ;
        for (int i = 0; i < CAPACITY; i++) begin
            n_rank[i] = r_rank[i];
        end

        if (r_state == ST_WB) begin
            if (r_cmd == CMD_GET) begin
                do_bump = r_hit_f;
            end else if (cap_eff != '0) begin
                if (r_hit_f) begin
                    do_bump = 1'b1;
                    val_we  = 1'b1;
                end else if ((OCC_W'(r_occ) < OCC_W'(cap_eff)) && r_free_f) begin
                    do_ins = 1'b1;
                    wr_idx = r_free_idx;
                end else if (r_vic_f) begin
                    do_ins   = 1'b1;
                    do_evict = 1'b1;
                    wr_idx   = r_vic_idx;
                end
            end
        end

        if (do_bump) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (r_valid[i] && (r_rank[i] < r_hit_rank)) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end
            end
            n_rank[r_hit_idx] = '0;
        end

        if (do_ins) begin
            // remove the victim (close its rank gap), then age everyone by one
            for (int i = 0; i < CAPACITY; i++) begin
                if (r_valid[i] && !(do_evict && (IDX_W'(i) == wr_idx))) begin
                    if (do_evict && (r_rank[i] > r_vic_rank)) begin
                        n_rank[i] = r_rank[i];
                    end else begin
                        n_rank[i] = r_rank[i] + 1'b1;
                    end
                end
            end
            n_valid[wr_idx] = 1'b1;
            n_rank[wr_idx]  = '0;
            if (!do_evict) begin
                n_occ = r_occ + 1'b1;
            end
        end

        if (do_ins) begin
            wr_cnt = t_cnt'(1);
        end else if (r_hit_cnt == COUNT_MAX) begin
            wr_cnt = r_hit_cnt;
        end else begin
            wr_cnt = r_hit_cnt + 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_occ      <= '0;
            r_capacity <= CAP_LIM;
            r_o_valid  <= 1'b0;
        end else begin
            r_o_valid <= (r_state == ST_WB);
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_ptr == LAST_IDX) begin
                        r_state <= ST_WB;
                    end
                end
                ST_WB: begin
                    r_valid   <= n_valid;
                    r_occ     <= n_occ;
                    r_state   <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath: request latch, scan, table writes, result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= i_command;
            r_key_in <= i_key;
            r_val_in <= i_value;
            r_ptr    <= '0;
            r_hit_f  <= 1'b0;
            r_free_f <= 1'b0;
            r_vic_f  <= 1'b0;
        end

        if (r_state == ST_SCAN) begin
            r_ptr <= r_ptr + 1'b1;
            if (key_match && !r_hit_f) begin
                r_hit_f    <= 1'b1;
                r_hit_idx  <= r_ptr;
                r_hit_val  <= r_value[r_ptr];
                r_hit_rank <= r_rank[r_ptr];
                r_hit_cnt  <= r_count[r_ptr];
            end
            if (!cur_valid && !r_free_f) begin
                r_free_f   <= 1'b1;
                r_free_idx <= r_ptr;
            end
            if (vic_better) begin
                r_vic_f    <= 1'b1;
                r_vic_idx  <= r_ptr;
                r_vic_cnt  <= r_count[r_ptr];
                r_vic_rank <= r_rank[r_ptr];
                r_vic_key  <= r_key[r_ptr];
            end
        end

        if (r_state == ST_WB) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_rank[i] <= n_rank[i];
            end
            if (do_bump || do_ins) begin
                r_count[wr_idx] <= wr_cnt;
            end
            if (val_we || do_ins) begin
                r_value[wr_idx] <= r_val_in;
            end
            if (do_ins) begin
                r_key[wr_idx] <= r_key_in;
            end
            r_o_hit <= r_hit_f;
            r_o_rv  <= (r_cmd == CMD_GET && r_hit_f) ? r_hit_val : '0;
            r_o_ev  <= do_evict;
            r_o_evk <= do_evict ? r_vic_key : '0;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_hit         = r_o_hit;
    assign o_read_value  = r_o_rv;
    assign o_evicted     = r_o_ev;
    assign o_evicted_key = r_o_evk;

    // Assertions
    a_res_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(CAPACITY))
        else $error("occupancy above table size");

    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_evicted) |-> !o_hit)
        else $error("eviction reported on a hit");

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import lfu_pkg::*;

    // Kinds of entry in the pending stimulus queue: a request for the block,
    // a capacity write, or a pause until the block has drained.
    typedef enum logic [1:0] {ITEM_REQUEST, ITEM_SET_CAPACITY, ITEM_WAIT_IDLE} t_item_kind;

    typedef struct packed {
        t_item_kind       kind;
        logic             cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic [CFG_W-1:0] cap;
        logic             no_gap;   // skip sender gaps (long back-to-back runs)
    } t_pending_item;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } t_table_resp;

    // DUT connections; every input known from time zero
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    start       = 1'b0;
    logic                    busy;
    logic                    i_command   = CMD_GET;
    logic signed [KEY_W-1:0] i_key       = '0;
    logic signed [VAL_W-1:0] i_value     = '0;
    logic                    o_valid;
    logic                    o_hit;
    logic signed [VAL_W-1:0] o_read_value;
    logic                    o_evicted;
    logic signed [KEY_W-1:0] o_evicted_key;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_W-1:0]        i_cfg_data  = '0;

    lfu_cache_table_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the table, kept in step with every request taken
    // ------------------------------------------------------------------
    logic             tbl_valid [CAPACITY];
    logic [KEY_W-1:0] tbl_key   [CAPACITY];
    logic [VAL_W-1:0] tbl_val   [CAPACITY];
    t_cnt             tbl_cnt   [CAPACITY];
    t_rank            tbl_rank  [CAPACITY];   // 0 = most recently used
    logic [OCC_W-1:0] tbl_occ;
    logic [CFG_W-1:0] tbl_cap;

    t_pending_item pending_q[$];
    t_table_resp   resp_expected_q[$];

    int fail_count   = 0;
    int req_total    = 0;
    int hit_total    = 0;
    int evict_total  = 0;
    int cap_writes   = 0;
    int burst_left   = 8;
    int gap_left     = 0;

    // Mark an entry as used: younger entries age by one, the entry becomes
    // the most recent, and its count rises unless already at the ceiling.
    function automatic void touch_entry(int e);
        t_rank old_rank;
        old_rank = tbl_rank[e];
        for (int i = 0; i < CAPACITY; i++)
            if (tbl_valid[i] && tbl_rank[i] < old_rank)
                tbl_rank[i]++;
        tbl_rank[e] = '0;
        if (tbl_cnt[e] != COUNT_MAX)
            tbl_cnt[e]++;
    endfunction

    // Apply one request to the shadow table and return the response it owes
    function automatic t_table_resp predict_table_access(logic cmd, logic [KEY_W-1:0] k,
                                                         logic [VAL_W-1:0] v);
        t_table_resp r;
        int          found;
        int          slot;
        int          lim;
        r     = '0;
        lim   = (tbl_cap > CAPACITY) ? CAPACITY : int'(tbl_cap);
        found = -1;
        for (int i = 0; i < CAPACITY; i++)
            if (found < 0 && tbl_valid[i] && tbl_key[i] == k)
                found = i;
        r.hit = (found >= 0);

        if (cmd == CMD_GET) begin
            if (found >= 0) begin
                r.read_value = tbl_val[found];
                touch_entry(found);
            end
        end else if (lim != 0) begin
            if (found >= 0) begin
                tbl_val[found] = v;
                touch_entry(found);
            end else begin
                slot = -1;
                if (tbl_occ < lim)
                    for (int i = 0; i < CAPACITY; i++)
                        if (slot < 0 && !tbl_valid[i])
                            slot = i;
                if (slot < 0) begin
                    // victim: lowest count, oldest among equal counts
                    for (int i = 0; i < CAPACITY; i++)
                        if (tbl_valid[i] && (slot < 0 || tbl_cnt[i] < tbl_cnt[slot] ||
                            (tbl_cnt[i] == tbl_cnt[slot] && tbl_rank[i] > tbl_rank[slot])))
                            slot = i;
                    if (slot >= 0) begin
                        r.evicted     = 1'b1;
                        r.evicted_key = tbl_key[slot];
                        for (int i = 0; i < CAPACITY; i++)
                            if (tbl_valid[i] && tbl_rank[i] > tbl_rank[slot])
                                tbl_rank[i]--;
                        tbl_valid[slot] = 1'b0;
                        if (tbl_occ > 0)
                            tbl_occ--;
                    end
                end
                if (slot >= 0) begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (tbl_valid[i])
                            tbl_rank[i]++;
                    tbl_valid[slot] = 1'b1;
                    tbl_key[slot]   = k;
                    tbl_val[slot]   = v;
                    tbl_cnt[slot]   = t_cnt'(1);
                    tbl_rank[slot]  = '0;
                    tbl_occ++;
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus queue helpers
    // ------------------------------------------------------------------
    function automatic void push_request(logic cmd, logic [KEY_W-1:0] k,
                                         logic [VAL_W-1:0] v, logic hurry);
        t_pending_item it;
        it        = '0;
        it.kind   = ITEM_REQUEST;
        it.cmd    = cmd;
        it.key    = k;
        it.val    = v;
        it.no_gap = hurry;
        pending_q.push_back(it);
    endfunction

    function automatic void push_capacity(logic [CFG_W-1:0] c);
        t_pending_item it;
        it      = '0;
        it.kind = ITEM_SET_CAPACITY;
        it.cap  = c;
        pending_q.push_back(it);
    endfunction

    function automatic void push_wait_idle();
        t_pending_item it;
        it      = '0;
        it.kind = ITEM_WAIT_IDLE;
        pending_q.push_back(it);
    endfunction

    // ------------------------------------------------------------------
    // Driver: feeds requests in bursts with random gaps, holds a request
    // while busy, and only writes capacity once the block has drained.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : req_driver
        logic             nx_start;
        logic             nx_cfg_valid;
        logic             nx_cmd;
        logic [KEY_W-1:0] nx_key;
        logic [VAL_W-1:0] nx_val;
        logic [CFG_W-1:0] nx_cfg;
        t_pending_item    head;

        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
            i_command   <= CMD_GET;
            i_key       <= '0;
            i_value     <= '0;
            i_cfg_data  <= '0;
        end else begin
            // default: nothing offered, junk on the idle fields
            nx_start     = 1'b0;
            nx_cfg_valid = 1'b0;
            nx_cmd       = 1'($urandom_range(0, 1));
            nx_key       = $urandom;
            nx_val       = $urandom;
            nx_cfg       = CFG_W'($urandom);

            // hold a request the block has not taken yet; drop one it has
            if (start && busy) begin
                nx_start = 1'b1;
                nx_cmd   = i_command;
                nx_key   = i_key;
                nx_val   = i_value;
            end else if (start) begin
                head = pending_q.pop_front();
            end

            if (i_cfg_valid && !o_cfg_ready) begin
                nx_cfg_valid = 1'b1;
                nx_cfg       = i_cfg_data;
            end else if (i_cfg_valid) begin
                head = pending_q.pop_front();
            end

            if (!nx_start && !nx_cfg_valid && pending_q.size() != 0) begin
                head = pending_q[0];
                if (head.kind == ITEM_REQUEST) begin
                    if (gap_left != 0 && !head.no_gap) begin
                        gap_left--;
                    end else begin
                        nx_start = 1'b1;
                        nx_cmd   = head.cmd;
                        nx_key   = head.key;
                        nx_val   = head.val;
                        if (burst_left > 1) begin
                            burst_left--;
                        end else begin
                            // new burst; a third of the time no gap at all
                            burst_left = $urandom_range(1, 48);
                            gap_left   = ($urandom_range(0, 2) == 0) ? 0
                                                                     : $urandom_range(1, 40);
                        end
                    end
                end else if (!start && !i_cfg_valid && !busy && !o_valid &&
                             resp_expected_q.size() == 0) begin
                    // block is drained: write capacity or release the pause
                    if (head.kind == ITEM_SET_CAPACITY) begin
                        nx_cfg_valid = 1'b1;
                        nx_cfg       = head.cap;
                    end else begin
                        head = pending_q.pop_front();
                    end
                end
            end

            start       <= nx_start;
            i_cfg_valid <= nx_cfg_valid;
            i_command   <= nx_cmd;
            i_key       <= nx_key;
            i_value     <= nx_val;
            i_cfg_data  <= nx_cfg;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every request taken, check every result strobe
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : resp_monitor
        t_table_resp want;

        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) begin
                tbl_valid[i] = 1'b0;
                tbl_key[i]   = '0;
                tbl_val[i]   = '0;
                tbl_cnt[i]   = '0;
                tbl_rank[i]  = '0;
            end
            tbl_occ = '0;
            tbl_cap = CFG_W'(CAPACITY);
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                tbl_cap = i_cfg_data;
                cap_writes++;
            end

            if (start && !busy) begin
                resp_expected_q.push_back(predict_table_access(i_command, i_key, i_value));
                req_total++;
            end

            if (o_valid) begin
                if (o_hit)
                    hit_total++;
                if (o_evicted)
                    evict_total++;
                if (resp_expected_q.size() == 0) begin
                    $error("result strobe with no request outstanding");
                    fail_count++;
                end else begin
                    want = resp_expected_q.pop_front();
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_hit);
                        fail_count++;
                    end
                    if (o_read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, o_read_value);
                        fail_count++;
                    end
                    if (o_evicted !== want.evicted) begin
                        $error("evicted: expected %0d, got %0d", want.evicted, o_evicted);
                        fail_count++;
                    end
                    if (o_evicted_key !== want.evicted_key) begin
                        $error("evicted_key: expected %0d, got %0d",
                               want.evicted_key, o_evicted_key);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int               phase_caps [10];
        int               pool_len;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] key_pool[$];
        logic [KEY_W-1:0] hot_key;

        // capacity 16 first so the table fills, then drop below occupancy
        phase_caps = '{16, 4, 0, 1, 31, 9, 16, 2, 17, 5};
        hot_key    = 32'h5A5A_0001;

        // Directed: empty table, extreme keys and values, overwrite
        push_request(CMD_GET, 32'h0000_0000, 32'h1234_5678, 1'b0);
        push_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        push_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        push_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
        push_request(CMD_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        push_request(CMD_GET, 32'h8000_0000, 32'h5555_5555, 1'b0);
        push_request(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        // capacity below occupancy: one eviction per new key, then a miss
        push_capacity(CFG_W'(2));
        push_request(CMD_PUT, 32'h0000_0001, 32'hAAAA_AAAA, 1'b0);
        push_request(CMD_PUT, 32'h0000_0002, 32'h5555_5555, 1'b0);
        push_request(CMD_GET, 32'h0000_0001, 32'h0000_0000, 1'b0);
        // capacity zero: puts change nothing but still report the hit
        push_capacity(CFG_W'(0));
        push_request(CMD_PUT, 32'h0000_0003, 32'h0BAD_0BAD, 1'b0);
        push_request(CMD_PUT, 32'h8000_0000, 32'h0BAD_0BAD, 1'b0);
        push_request(CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b0);
        push_request(CMD_GET, 32'h0000_0003, 32'h0000_0000, 1'b0);
        // capacity above the table size, then equal counts settled by age
        push_capacity(CFG_W'(31));
        push_request(CMD_PUT, 32'h0000_0010, 32'h0000_0010, 1'b0);
        push_request(CMD_PUT, 32'h0000_0011, 32'h0000_0011, 1'b0);
        push_capacity(CFG_W'(1));
        push_request(CMD_PUT, 32'h0000_0012, 32'h0000_0012, 1'b0);
        push_request(CMD_PUT, 32'h0000_0013, 32'h0000_0013, 1'b0);
        push_wait_idle();

        // Raise one entry's use count well above the rest; it must then
        // survive as the most used entry when a fresh key is evicted.
        push_capacity(CFG_W'(2));
        push_request(CMD_PUT, hot_key, 32'hC0FF_EE00, 1'b0);
        repeat (20) push_request(CMD_GET, hot_key, $urandom, 1'b1);
        push_request(CMD_PUT, 32'h0000_0020, 32'h0000_0020, 1'b0);
        push_request(CMD_PUT, 32'h0000_0021, 32'h0000_0021, 1'b0);
        push_request(CMD_GET, hot_key, 32'h0000_0000, 1'b0);

        // Random phases: keys mostly from a small pool so hits and
        // evictions are frequent, with the odd fully random key.
        for (int p = 0; p < 10; p++) begin
            push_capacity(CFG_W'(phase_caps[p]));
            key_pool.delete();
            key_pool.push_back(32'h8000_0000);
            key_pool.push_back(32'h7FFF_FFFF);
            key_pool.push_back(32'h0000_0000);
            key_pool.push_back(32'hFFFF_FFFF);
            pool_len = ((phase_caps[p] > CAPACITY) ? CAPACITY : phase_caps[p]) +
                       $urandom_range(2, 8);
            repeat (pool_len) key_pool.push_back($urandom);
            repeat (150) begin
                if ($urandom_range(0, 99) == 0)
                    push_wait_idle();
                k = ($urandom_range(0, 9) == 0) ? $urandom
                                                : key_pool[$urandom_range(0, key_pool.size() - 1)];
                push_request(1'($urandom_range(0, 1)), k, $urandom, 1'b0);
            end
        end

        // Release reset; it is never asserted again
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || resp_expected_q.size() != 0 || busy)
            @(posedge i_clk);
        // allow for a stray result beyond the normal latency
        repeat (40) @(posedge i_clk);

        $display("Run covered %0d requests with %0d hits and %0d evictions over %0d capacity",
                 req_total, hit_total, evict_total, cap_writes);
        $display("writes, including capacity zero, above the table and below occupancy.");
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
